// File: design/knn_pkg.sv
`timescale 1ns / 1ps
package knn_pkg;
	localparam int MAX_VECTORS = 256;
	localparam int DIMENSION   = 16;
	localparam int MAX_K       = 8;
	localparam int VEC_AW      = $clog2(MAX_VECTORS);
	localparam int DIM_AW      = $clog2(DIMENSION);
	localparam int CNT_W       = VEC_AW + 1;
	localparam int STORE_AW    = VEC_AW + DIM_AW;
	localparam int DIST_W      = 40;
	localparam int K_AW        = $clog2(MAX_K);
	localparam logic [DIST_W-1:0] DIST_ONES = {DIST_W{1'b1}};

	typedef enum logic [1:0] {
		ACT_TRAIN = 2'd0,
		ACT_QUERY = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		DM_MANHATTAN = 2'd0,
		DM_CHEBYSHEV = 2'd1,
		DM_EUCLID    = 2'd2,
		DM_OTHER     = 2'd3
	} dist_mode_t;

	localparam logic REG_K    = 1'b0;
	localparam logic REG_MODE = 1'b1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_VOTE,
		ST_EMIT,
		ST_INIT
	} state_t;

	typedef struct packed {
		logic [7:0] voted_class;
		logic       has_vote;
		logic       store_full;
		logic       is_query_result;
	} result_t;
endpackage

// File: design/knn_ram.sv
`timescale 1ns / 1ps
module knn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: design/knn_dist.sv
`timescale 1ns / 1ps
// Distance unit: one element a cycle, register after the multiply.
module knn_dist import knn_pkg::*; (
	input  logic              clk,
	input  logic              start,
	input  logic              in_valid,
	input  logic              in_last,
	input  logic [15:0]       qa,
	input  logic [15:0]       sb,
	input  dist_mode_t        mode,
	output logic              done,
	output logic [DIST_W-1:0] dist_sum
);
	logic [16:0]       diff;
	logic [16:0]       diff_s1;
	logic [33:0]       sq_s1;
	logic              v_s1, last_s1;
	logic [DIST_W-1:0] acc_q;
	logic [DIST_W-1:0] nxt;

	always_comb begin
		if ($signed(qa) > $signed(sb)) begin
			diff = 17'($signed({qa[15], qa}) - $signed({sb[15], sb}));
		end else begin
			diff = 17'($signed({sb[15], sb}) - $signed({qa[15], qa}));
		end
	end

	always_ff @(posedge clk) begin
		v_s1    <= in_valid;
		last_s1 <= in_valid & in_last;
		diff_s1 <= diff;
		sq_s1   <= diff * diff;
	end

	always_comb begin
		case (mode)
			DM_CHEBYSHEV: nxt = ({23'd0, diff_s1} > acc_q) ? {23'd0, diff_s1} : acc_q;
			DM_EUCLID:    nxt = acc_q + {6'd0, sq_s1};
			default:      nxt = acc_q + {23'd0, diff_s1};
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else if (v_s1) begin
			acc_q <= nxt;
		end
		done <= v_s1 & last_s1;
	end

	assign dist_sum = acc_q;
endmodule

// File: design/knn_classifier.sv
`timescale 1ns / 1ps
// k-nearest-neighbour classifier.
// s_axis carries one request per feature element: action (train, query, clear)
// in tuser, feature and class label in tdata. Elements load at one per cycle
// into a synchronous vector memory (train) or query buffer (query); a pending
// result holds the input off until it has been taken, as does a running query.
// The last train element of a vector returns an acknowledge on m_axis, with
// store_full set when the store already holds 256 vectors and the vector is
// dropped. The last query element starts a walk over the stored vectors,
// newest first: each vector goes through the vector memory read port and
// the distance unit, then a search for the worst of the k (up to 8) slots.
// The vote increments the counter of each filled slot's label, then sweeps
// all 256 class counters before the result is emitted.
// Voting counters live in a small memory; the sweep writes each back to zero.
// Configuration writes set k_neighbors (0) and distance_mode (1); the user must
// make them only while idle, as the block does not enforce it. Reset clears
// the registers (k = 3, Manhattan), then a clearing pass zeroes the vote
// counters with the input held off; the vector, label and query memories keep
// their contents. A stalled receiver holds the result and blocks new input.
module knn_classifier import knn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // feature[15:0], class_label[23:16]
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // voted_class[7:0], has_vote, store_full, is_query_result
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);
	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [DIM_AW-1:0] pos_q;
	logic [7:0]       pend_q;
	logic [3:0]       k_q;
	dist_mode_t       mode_q;
	logic             out_v_q;
	result_t          res_q;

	logic [15:0] feat;
	logic [7:0]  lbl;
	action_t     act;
	logic        acc, last;
	assign feat = s_tdata[15:0];
	assign lbl  = s_tdata[23:16];
	assign act  = action_t'(s_tuser);
	assign acc  = s_tvalid & s_tready;
	assign last = (pos_q == DIM_AW'(DIMENSION - 1));

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_LOAD) & ~out_v_q;
	assign m_tvalid  = out_v_q;
	assign m_tdata   = {5'd0, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= 4'd3;
			mode_q <= DM_MANHATTAN;
		end else if (cfg_valid) begin
			if (cfg_index == REG_K) k_q <= cfg_data;
			else mode_q <= dist_mode_t'(cfg_data[1:0]);
		end
	end

	logic [K_AW:0] keff;
	always_comb begin
		if (k_q == 4'd0) keff = (K_AW+1)'(1);
		else if (k_q > 4'(MAX_K)) keff = (K_AW+1)'(MAX_K);
		else keff = (K_AW+1)'(k_q);
	end

	// Scan control
	logic [CNT_W-1:0]  slot_q;      // slot+1 being walked
	logic [DIM_AW:0]   rd_q;        // element read index, DIMENSION = done issuing
	logic              busy_q;      // distance in flight
	logic              rd_v_s1;
	logic              rd_last_s1;
	logic [DIST_W-1:0] bd_q [MAX_K];
	logic [7:0]        bl_q [MAX_K];
	logic [K_AW:0]     si_q;        // worst search index
	logic [K_AW-1:0]   worst_q;
	logic              srch_q;
	logic [7:0]        lab_s;
	logic [8:0]        vi_q;        // vote sweep index, clearing pass index
	logic [K_AW:0]     vk_q;        // slot counting phase
	logic [7:0]        win_q;
	logic [3:0]        bc_q;

	// Memories
	logic [15:0] vrd, qrd;
	logic [7:0]  lrd;
	logic [STORE_AW-1:0] vraddr;
	logic [DIM_AW-1:0]   qraddr;
	logic [VEC_AW-1:0]   slot_ix;
	logic vwe, qwe, lwe;
	assign slot_ix = VEC_AW'(slot_q - 1'b1);
	assign vraddr  = {slot_ix, rd_q[DIM_AW-1:0]};
	assign qraddr  = rd_q[DIM_AW-1:0];
	assign vwe = acc & (act == ACT_TRAIN) & (count_q < CNT_W'(MAX_VECTORS));
	assign qwe = acc & (act == ACT_QUERY);
	assign lwe = vwe & last;

	knn_ram #(.WIDTH(16), .DEPTH(MAX_VECTORS*DIMENSION)) u_vec (
		.clk, .we(vwe), .waddr({count_q[VEC_AW-1:0], pos_q}), .wdata(feat),
		.raddr(vraddr), .rdata(vrd));
	knn_ram #(.WIDTH(16), .DEPTH(DIMENSION)) u_qry (
		.clk, .we(qwe), .waddr(pos_q), .wdata(feat), .raddr(qraddr), .rdata(qrd));
	knn_ram #(.WIDTH(8), .DEPTH(MAX_VECTORS)) u_lbl (
		.clk, .we(lwe), .waddr(count_q[VEC_AW-1:0]),
		.wdata((pos_q == '0) ? lbl : pend_q), .raddr(slot_ix), .rdata(lrd));

	// Vote counters: read-modify-write; clear on sweep read.
	logic       cwe;
	logic [7:0] cwa, cra;
	logic [3:0] cwd, crd;
	knn_ram #(.WIDTH(4), .DEPTH(256)) u_cnt (
		.clk, .we(cwe), .waddr(cwa), .wdata(cwd), .raddr(cra), .rdata(crd));

	logic              ddone;
	logic [DIST_W-1:0] walk_dist;
	knn_dist u_dist (
		.clk, .start(state_q == ST_SCAN && rd_q == '0 && !busy_q),
		.in_valid(rd_v_s1), .in_last(rd_last_s1), .qa(qrd), .sb(vrd),
		.mode(mode_q), .done(ddone), .dist_sum(walk_dist));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: if (vi_q == 9'd255) state_d = ST_LOAD;
			ST_LOAD: if (acc && act == ACT_QUERY && last) state_d = ST_SCAN;
			ST_SCAN: if (slot_q == '0 && !busy_q && !srch_q) state_d = ST_VOTE;
			ST_VOTE: if (vi_q == 9'd256) state_d = ST_EMIT;
			ST_EMIT: state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_INIT;
		else state_q <= state_d;
	end

	// Vote counter port: during VOTE, phase vk<keff increments slot labels;
	// each label is read, then written next cycle, and repeated labels would
	// collide, so the last write is forwarded.
	logic [7:0] pw_a;
	logic [3:0] pw_d;
	logic       pw_v;
	logic       inc_s1;
	logic [7:0] inc_a_s1;
	logic       swp_s1;
	logic [7:0] swp_a_s1;
	logic [3:0] cur;
	assign cur = (pw_v && pw_a == inc_a_s1) ? pw_d : crd;

	always_comb begin
		cra = 8'd0;
		if (state_q == ST_VOTE) begin
			if (vk_q < keff) cra = bl_q[vk_q[K_AW-1:0]];
			else cra = vi_q[7:0];
		end
		cwe = 1'b0; cwa = 8'd0; cwd = 4'd0;
		if (state_q == ST_INIT) begin
			cwe = 1'b1; cwa = vi_q[7:0];
		end
		if (inc_s1) begin
			cwe = 1'b1; cwa = inc_a_s1; cwd = cur + 4'd1;
		end else if (swp_s1) begin
			cwe = 1'b1; cwa = swp_a_s1; cwd = 4'd0;
		end
	end

	logic [3:0] sw_cnt;
	assign sw_cnt = (pw_v && pw_a == swp_a_s1) ? pw_d : crd;

	logic [DIST_W-1:0] ins_dist;
	assign ins_dist = walk_dist;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; pos_q <= '0; pend_q <= '0; res_q <= '0;
			out_v_q <= 1'b0; slot_q <= '0; rd_q <= '0; busy_q <= 1'b0;
			rd_v_s1 <= 1'b0; rd_last_s1 <= 1'b0; si_q <= '0; worst_q <= '0;
			srch_q <= 1'b0; vi_q <= '0; vk_q <= '0; win_q <= '0; bc_q <= '0;
			inc_s1 <= 1'b0; swp_s1 <= 1'b0; pw_v <= 1'b0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			rd_last_s1 <= 1'b0;
			inc_s1 <= 1'b0;
			swp_s1 <= 1'b0;
			pw_v <= cwe; pw_a <= cwa; pw_d <= cwd;
			case (state_q)
				ST_INIT: vi_q <= vi_q + 1'b1;
				ST_LOAD: if (acc) begin
					if (act == ACT_CLEAR) begin
						count_q <= '0; pos_q <= '0;
					end else if (act != ACT_NONE) begin
						pos_q <= last ? '0 : pos_q + 1'b1;
						if (act == ACT_TRAIN) begin
							if (pos_q == '0) pend_q <= lbl;
							if (last) begin
								out_v_q <= 1'b1;
								res_q <= '{8'd0, 1'b0,
									count_q >= CNT_W'(MAX_VECTORS), 1'b0};
								if (count_q < CNT_W'(MAX_VECTORS))
									count_q <= count_q + 1'b1;
							end
						end else if (last) begin
							slot_q <= count_q; rd_q <= '0; busy_q <= 1'b0;
							srch_q <= 1'b0;
							for (int i = 0; i < MAX_K; i++) begin
								bd_q[i] <= DIST_ONES; bl_q[i] <= 8'd0;
							end
						end
					end
				end
				ST_SCAN: begin
					if (slot_q != '0 && !busy_q && !srch_q) begin
						if (rd_q != (DIM_AW+1)'(DIMENSION)) begin
							rd_v_s1 <= 1'b1;
							rd_last_s1 <= (rd_q == (DIM_AW+1)'(DIMENSION-1));
							rd_q <= rd_q + 1'b1;
						end else begin
							busy_q <= 1'b1;
						end
					end
					if (ddone) begin
						srch_q <= 1'b1; si_q <= (K_AW+1)'(1); worst_q <= '0;
						lab_s <= lrd;
					end
					if (srch_q) begin
						if (si_q < keff) begin
							if (bd_q[si_q[K_AW-1:0]] > bd_q[worst_q])
								worst_q <= si_q[K_AW-1:0];
							si_q <= si_q + 1'b1;
						end else begin
							if (ins_dist < bd_q[worst_q]) begin
								bd_q[worst_q] <= ins_dist;
								bl_q[worst_q] <= lab_s;
							end
							srch_q <= 1'b0; busy_q <= 1'b0; rd_q <= '0;
							slot_q <= slot_q - 1'b1;
						end
					end
					if (state_d == ST_VOTE) begin
						vk_q <= '0; vi_q <= '0; win_q <= '0; bc_q <= '0;
					end
				end
				ST_VOTE: begin
					if (vk_q < keff) begin
						inc_s1 <= (bd_q[vk_q[K_AW-1:0]] != DIST_ONES);
						inc_a_s1 <= bl_q[vk_q[K_AW-1:0]];
						vk_q <= vk_q + 1'b1;
					end else begin
						// sweep follows the last increment at once; forwarding
						// covers a counter read in the cycle it is written
						if (vi_q != 9'd256) begin
							swp_s1 <= 1'b1; swp_a_s1 <= vi_q[7:0];
							vi_q <= vi_q + 1'b1;
						end
					end
					if (swp_s1 && swp_a_s1 != 8'd0 && sw_cnt > bc_q) begin
						bc_q <= sw_cnt; win_q <= swp_a_s1;
					end
				end
				ST_EMIT: begin
					// fold in last swept counter
					if (swp_s1 && swp_a_s1 != 8'd0 && sw_cnt > bc_q) begin
						res_q <= '{swp_a_s1, 1'b1, 1'b0, 1'b1};
					end else begin
						res_q <= '{win_q, bc_q != '0, 1'b0, 1'b1};
					end
					out_v_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Swept counters are written back to zero, so the next vote starts clear.
	// The label memory must be read for the walked slot: it follows slot_ix,
	// stable for the whole slot, so lrd is valid at ddone.

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == ST_LOAD && !out_v_q))
		else $error("input taken while busy");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VECTORS))
		else $error("store count overflow");
	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |=> m_tvalid && m_tdata[0])
		else $error("query result missing");
endmodule

// File: tb/sv/knn_classifier_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the k-nearest-neighbour classifier.
// A table of directed vectors comes first, then random element streams over
// a small store, with configuration changes between drained stretches.
module knn_classifier_tb;
	import knn_pkg::*;

	localparam int WATCHDOG_CYCLES = 60000;
	localparam int TAIL_CYCLES     = 300;
	localparam int RANDOM_ITEMS    = 450;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = ACT_NONE;
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [15:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_K;
	logic [3:0]  cfg_data = '0;

	always #5 clk = ~clk;

	knn_classifier DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow of the classifier state
	logic [15:0] shadow_vectors [MAX_VECTORS*DIMENSION];
	logic [7:0]  shadow_labels [MAX_VECTORS];
	logic [15:0] shadow_query [DIMENSION];
	bit          vec_written [MAX_VECTORS*DIMENSION];
	bit          query_written [DIMENSION];
	int          vec_count = 0;
	int          elem_pos = 0;
	logic [7:0]  held_label = '0;
	logic [3:0]  k_setting = 4'd3;
	dist_mode_t  mode_setting = DM_MANHATTAN;

	result_t     pending_results [$];
	int          errors = 0;
	bit          send_gaps = 1'b1;
	bit          recv_stalls = 1'b1;

	function automatic logic [DIST_W-1:0] vector_distance(int slot);
		longint acc = 0;
		longint diff;
		int a, b;
		for (int d = 0; d < DIMENSION; d++) begin
			a = $signed(shadow_query[d]);
			b = $signed(shadow_vectors[slot*DIMENSION + d]);
			diff = (a > b) ? a - b : b - a;
			case (mode_setting)
				DM_CHEBYSHEV: if (diff > acc) acc = diff;
				DM_EUCLID:    acc += diff * diff;
				default:      acc += diff;
			endcase
		end
		return (acc > longint'(DIST_ONES)) ? DIST_ONES : acc[DIST_W-1:0];
	endfunction

	function automatic result_t classify();
		result_t r;
		logic [DIST_W-1:0] near_dist [MAX_K];
		logic [7:0] near_label [MAX_K];
		logic [DIST_W-1:0] cand_dist;
		int votes [256];
		int k, worst, top, winner;
		k = (k_setting == 0) ? 1 : (k_setting > MAX_K) ? MAX_K : k_setting;
		for (int i = 0; i < MAX_K; i++) begin
			near_dist[i] = DIST_ONES;
			near_label[i] = '0;
		end
		for (int s = vec_count - 1; s >= 0; s--) begin
			cand_dist = vector_distance(s);
			worst = 0;
			for (int i = 1; i < k; i++)
				if (near_dist[i] > near_dist[worst]) worst = i;
			if (cand_dist < near_dist[worst]) begin
				near_dist[worst] = cand_dist;
				near_label[worst] = shadow_labels[s];
			end
		end
		foreach (votes[i]) votes[i] = 0;
		for (int i = 0; i < k; i++)
			if (near_dist[i] != DIST_ONES) votes[near_label[i]]++;
		top = 0;
		winner = 0;
		// label zero never votes; strict compare lets the lowest class win ties
		for (int c = 1; c < 256; c++)
			if (votes[c] > top) begin
				top = votes[c];
				winner = c;
			end
		r.voted_class = winner[7:0];
		r.has_vote = (top != 0);
		r.store_full = 1'b0;
		r.is_query_result = 1'b1;
		return r;
	endfunction

	// advance the shadow state by one accepted request; returns 1 with a result
	function automatic bit predict_element(action_t a, logic [15:0] f, logic [7:0] l,
			output result_t r);
		bit last;
		r = '0;
		if (a == ACT_CLEAR) begin
			vec_count = 0;
			elem_pos = 0;
			return 1'b0;
		end
		if (a == ACT_NONE) return 1'b0;
		last = (elem_pos == DIMENSION - 1);
		if (a == ACT_QUERY) begin
			shadow_query[elem_pos] = f;
			query_written[elem_pos] = 1'b1;
			elem_pos = last ? 0 : elem_pos + 1;
			if (last) r = classify();
			return last;
		end
		if (elem_pos == 0) held_label = l;
		if (vec_count < MAX_VECTORS) begin
			shadow_vectors[vec_count*DIMENSION + elem_pos] = f;
			vec_written[vec_count*DIMENSION + elem_pos] = 1'b1;
		end
		elem_pos = last ? 0 : elem_pos + 1;
		if (!last) return 1'b0;
		if (vec_count < MAX_VECTORS) begin
			shadow_labels[vec_count] = held_label;
			vec_count++;
		end else begin
			r.store_full = 1'b1;
		end
		return 1'b1;
	endfunction

	// a completing element must never make the block read an unwritten entry
	function automatic bit safe_element(action_t a);
		if (elem_pos != DIMENSION - 1 || a == ACT_CLEAR || a == ACT_NONE) return 1'b1;
		for (int i = 0; i < DIMENSION - 1; i++) begin
			if (a == ACT_QUERY && !query_written[i]) return 1'b0;
			if (a == ACT_TRAIN && vec_count < MAX_VECTORS
					&& !vec_written[vec_count*DIMENSION + i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic report(string what, int got, int want);
		$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	// send one element request; a typed expectation overrides the prediction
	task automatic send_element(action_t a, logic [15:0] f, logic [7:0] l,
			bit typed = 1'b0, result_t typed_res = '0);
		result_t r;
		if (send_gaps && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {l, f};
		s_tuser <= a;
		do @(posedge clk); while (!s_tready);
		if (predict_element(a, f, l, r)) pending_results.push_back(typed ? typed_res : r);
	endtask

	// hold off until every outstanding result has come back, then let the walk settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [3:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_K) k_setting = val;
		else mode_setting = dist_mode_t'(val[1:0]);
	endtask

	// receiver: stall about one cycle in ten while stalls are enabled
	always @(posedge clk)
		m_tready <= recv_stalls ? ($urandom_range(0, 99) >= 10) : 1'b1;

	// result checker
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[10:0];
			if (pending_results.size() == 0) begin
				report("unexpected result, voted_class", got.voted_class, 0);
			end else begin
				want = pending_results.pop_front();
				if (got.voted_class != want.voted_class)
					report("voted_class", got.voted_class, want.voted_class);
				if (got.has_vote != want.has_vote)
					report("has_vote", got.has_vote, want.has_vote);
				if (got.store_full != want.store_full)
					report("store_full", got.store_full, want.store_full);
				if (got.is_query_result != want.is_query_result)
					report("is_query_result", got.is_query_result, want.is_query_result);
			end
		end
	end

	// watchdog: count cycles in which no request moves on any channel
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	typedef enum int {ROW_VEC, ROW_CFG, ROW_NOISE, ROW_CLEAR} row_kind_t;
	typedef struct {
		row_kind_t   kind;
		action_t     act;
		logic [7:0]  label;
		logic [15:0] feat;
		bit          alternate;   // odd positions carry the most negative value
		bit          typed;
		result_t     res;
	} dir_row_t;

	localparam result_t ACK      = '{8'd0, 1'b0, 1'b0, 1'b0};
	localparam result_t NO_VOTE  = '{8'd0, 1'b0, 1'b0, 1'b1};

	dir_row_t dir_rows [] = '{
		'{ROW_VEC,   ACT_QUERY, 8'd0,   16'h0000, 0, 1, NO_VOTE}, // empty store
		'{ROW_VEC,   ACT_TRAIN, 8'd255, 16'h7fff, 0, 1, ACK},
		'{ROW_VEC,   ACT_TRAIN, 8'd1,   16'h8000, 0, 1, ACK},
		'{ROW_VEC,   ACT_TRAIN, 8'd0,   16'h0000, 0, 1, ACK},     // label zero never votes
		'{ROW_VEC,   ACT_TRAIN, 8'd7,   16'h7fff, 1, 1, ACK},
		'{ROW_NOISE, ACT_NONE,  8'hff,  16'hffff, 0, 0, ACK},
		'{ROW_VEC,   ACT_QUERY, 8'd0,   16'h7fff, 0, 0, ACK},
		'{ROW_CFG,   ACT_NONE,  8'd1,   16'd1,    0, 0, ACK},     // chebyshev
		'{ROW_VEC,   ACT_QUERY, 8'd0,   16'h8000, 0, 0, ACK},
		'{ROW_CFG,   ACT_NONE,  8'd1,   16'd2,    0, 0, ACK},     // squared euclidean
		'{ROW_VEC,   ACT_QUERY, 8'd0,   16'h7fff, 1, 0, ACK},
		'{ROW_CFG,   ACT_NONE,  8'd1,   16'd3,    0, 0, ACK},     // unknown mode
		'{ROW_CFG,   ACT_NONE,  8'd0,   16'd0,    0, 0, ACK},     // k of zero
		'{ROW_VEC,   ACT_QUERY, 8'd0,   16'h0000, 0, 0, ACK},
		'{ROW_CFG,   ACT_NONE,  8'd0,   16'd8,    0, 0, ACK},
		'{ROW_VEC,   ACT_QUERY, 8'd0,   16'd100,  0, 0, ACK},
		'{ROW_CFG,   ACT_NONE,  8'd0,   16'd15,   0, 0, ACK},     // k above the maximum
		'{ROW_VEC,   ACT_QUERY, 8'd0,   16'hfffb, 0, 0, ACK},
		'{ROW_CLEAR, ACT_CLEAR, 8'd0,   16'h0000, 0, 0, ACK},
		'{ROW_VEC,   ACT_QUERY, 8'd0,   16'h1234, 0, 1, NO_VOTE}, // store cleared
		'{ROW_CFG,   ACT_NONE,  8'd0,   16'd3,    0, 0, ACK},
		'{ROW_CFG,   ACT_NONE,  8'd1,   16'd0,    0, 0, ACK}
	};

	initial begin
		action_t run_act, a;
		bit wide;
		int items;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table: each vector row expands to a whole vector of elements
		foreach (dir_rows[r]) begin
			case (dir_rows[r].kind)
				ROW_VEC:
					for (int i = 0; i < DIMENSION; i++)
						send_element(dir_rows[r].act,
							(dir_rows[r].alternate && i[0]) ? 16'h8000 : dir_rows[r].feat,
							dir_rows[r].label, i == DIMENSION - 1 && dir_rows[r].typed,
							dir_rows[r].res);
				ROW_CFG:   write_reg(dir_rows[r].label[0], dir_rows[r].feat[3:0]);
				default:   send_element(dir_rows[r].act, dir_rows[r].feat, dir_rows[r].label);
			endcase
		end

		// random streams: mostly whole vectors, some stray or broken elements
		items = 0;
		run_act = ACT_TRAIN;
		wide = 1'b0;
		while (items < RANDOM_ITEMS) begin
			// leave one long stretch with neither side idling
			send_gaps = !(items > 200 && items < 320);
			recv_stalls = send_gaps;
			if (elem_pos == 0) begin
				if (items % 130 < 16 && items > 16) begin
					write_reg(REG_K, 4'($urandom_range(0, 15)));
					write_reg(REG_MODE, 4'($urandom_range(0, 3)));
				end
				if (vec_count > 20 && $urandom_range(0, 99) < 30) begin
					send_element(ACT_CLEAR, 16'($urandom), 8'($urandom));
					items++;
					continue;
				end
				run_act = ($urandom_range(0, 99) < 55) ? ACT_TRAIN : ACT_QUERY;
				wide = $urandom_range(0, 1);
			end
			a = ($urandom_range(0, 99) < 8) ? action_t'($urandom_range(0, 3)) : run_act;
			if (!safe_element(a)) a = safe_element(run_act) ? run_act : ACT_CLEAR;
			send_element(a, wide ? 16'($urandom) : 16'($urandom_range(0, 31) - 16),
				($urandom_range(0, 99) < 80) ? 8'($urandom_range(1, 4)) : 8'($urandom));
			if (a != ACT_NONE) items++;
		end

		send_gaps = 1'b1;
		recv_stalls = 1'b1;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// File: sim.f
design/knn_pkg.sv
design/knn_ram.sv
design/knn_dist.sv
design/knn_classifier.sv
tb/sv/knn_classifier_tb.sv
